FILE: rtl/lst_pkg.sv
`timescale 1ns / 1ps

package lst_pkg;

  // Default coordinate width and queue depth
  localparam int LST_COORD_BITS  = 12;
  localparam int LST_QUEUE_DEPTH = 2;

  // Item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Width of a packed command between front and back:
  // is_step, x, y, twice major, twice minor, error, pixels left, steep, minor sign
  function automatic int lst_cmd_width(input int coord_bits);
    return 6 * coord_bits + 8;
  endfunction

  // Width of a packed result: x, y, valid, last
  function automatic int lst_res_width(input int coord_bits);
    return 2 * coord_bits + 2;
  endfunction

endpackage

FILE: rtl/lst_fifo.sv
`timescale 1ns / 1ps

module lst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_fire;
  logic             rd_fire;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_fire = wr_en && !full;
  assign rd_fire = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store incoming entry
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_fire, rd_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/lst_front.sv
`timescale 1ns / 1ps

module lst_front import lst_pkg::*; #(
  parameter int COORD_BITS = LST_COORD_BITS
) (
  input  logic                                 func,
  input  logic [COORD_BITS-1:0]                start_x,
  input  logic [COORD_BITS-1:0]                start_y,
  input  logic [COORD_BITS-1:0]                end_x,
  input  logic [COORD_BITS-1:0]                end_y,
  output logic [lst_cmd_width(COORD_BITS)-1:0] cmd
);

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  typedef struct packed {
    logic                 is_step;
    logic [C-1:0]         x;
    logic [C-1:0]         y;
    logic [C:0]           tmaj;
    logic [C:0]           tmin;
    logic signed [EW-1:0] err;
    logic [C-1:0]         left;
    logic                 steep;
    logic                 minor_neg;
  } cmd_t;

  cmd_t         cmd_s;
  logic [C-1:0] adx;
  logic [C-1:0] ady;
  logic         x_major;
  logic         swap;
  logic [C-1:0] bx, by, fx, fy;
  logic [C-1:0] dmaj;
  logic [C-1:0] dmin;

  // Classify the line and set up the walk from the lower end of the major axis
  always_comb begin
    adx     = (start_x > end_x) ? start_x - end_x : end_x - start_x;
    ady     = (start_y > end_y) ? start_y - end_y : end_y - start_y;
    x_major = (ady < adx);
    swap    = x_major ? (start_x > end_x) : (start_y > end_y);
    bx      = swap ? end_x : start_x;
    by      = swap ? end_y : start_y;
    fx      = swap ? start_x : end_x;
    fy      = swap ? start_y : end_y;
    dmaj    = x_major ? adx : ady;
    dmin    = x_major ? ady : adx;

    cmd_s.is_step   = (func == FUNC_STEP);
    cmd_s.x         = bx;
    cmd_s.y         = by;
    cmd_s.tmaj      = {dmaj, 1'b0};
    cmd_s.tmin      = {dmin, 1'b0};
    cmd_s.err       = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
    cmd_s.left      = dmaj;
    cmd_s.steep     = !x_major;
    cmd_s.minor_neg = x_major ? (fy < by) : (fx < bx);
  end

  assign cmd = cmd_s;

endmodule

FILE: rtl/lst_back.sv
`timescale 1ns / 1ps

module lst_back import lst_pkg::*; #(
  parameter int COORD_BITS = LST_COORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_empty,
  input  logic [lst_cmd_width(COORD_BITS)-1:0] cmd,
  output logic                                 cmd_pop,
  input  logic                                 res_full,
  output logic                                 res_push,
  output logic [lst_res_width(COORD_BITS)-1:0] res
);

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  typedef struct packed {
    logic                 is_step;
    logic [C-1:0]         x;
    logic [C-1:0]         y;
    logic [C:0]           tmaj;
    logic [C:0]           tmin;
    logic signed [EW-1:0] err;
    logic [C-1:0]         left;
    logic                 steep;
    logic                 minor_neg;
  } cmd_t;

  typedef struct packed {
    logic [C-1:0] x;
    logic [C-1:0] y;
    logic         valid;
    logic         last;
  } res_t;

  cmd_t cmd_s;
  res_t res_s;

  // Line state
  logic [C-1:0]         cur_x, cur_x_next;
  logic [C-1:0]         cur_y, cur_y_next;
  logic signed [EW-1:0] err_term, err_term_next;
  logic [C:0]           twice_major, twice_major_next;
  logic [C:0]           twice_minor, twice_minor_next;
  logic [C-1:0]         pixels_left, pixels_left_next;
  logic                 steep_flag, steep_flag_next;
  logic                 minor_negative, minor_negative_next;

  logic                 go;
  logic                 step_minor;
  logic signed [EW-1:0] err_sub;
  logic [C-1:0]         minor_cur;
  logic [C-1:0]         minor_nxt;
  logic [C-1:0]         major_nxt;

  assign cmd_s    = cmd;
  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;
  assign res      = res_s;

  // Compute the next pixel and the result for the command at the queue head
  always_comb begin
    cur_x_next          = cur_x;
    cur_y_next          = cur_y;
    err_term_next       = err_term;
    twice_major_next    = twice_major;
    twice_minor_next    = twice_minor;
    pixels_left_next    = pixels_left;
    steep_flag_next     = steep_flag;
    minor_negative_next = minor_negative;

    step_minor = (err_term > 0);
    err_sub    = step_minor ? err_term - $signed({2'b00, twice_major}) : err_term;
    minor_cur  = steep_flag ? cur_x : cur_y;
    minor_nxt  = minor_negative ? minor_cur - 1'b1 : minor_cur + 1'b1;
    major_nxt  = (steep_flag ? cur_y : cur_x) + 1'b1;

    res_s = '0;

    if (!cmd_s.is_step) begin
      // Load a new line, drop any old one
      cur_x_next          = cmd_s.x;
      cur_y_next          = cmd_s.y;
      err_term_next       = cmd_s.err;
      twice_major_next    = cmd_s.tmaj;
      twice_minor_next    = cmd_s.tmin;
      pixels_left_next    = cmd_s.left;
      steep_flag_next     = cmd_s.steep;
      minor_negative_next = cmd_s.minor_neg;
      res_s.x             = cmd_s.x;
      res_s.y             = cmd_s.y;
      res_s.valid         = 1'b1;
      res_s.last          = (cmd_s.left == '0);
    end else if (pixels_left != '0) begin
      // Advance one pixel along the major axis
      err_term_next    = err_sub + $signed({2'b00, twice_minor});
      pixels_left_next = pixels_left - 1'b1;
      if (steep_flag) begin
        cur_y_next = major_nxt;
        cur_x_next = step_minor ? minor_nxt : cur_x;
      end else begin
        cur_x_next = major_nxt;
        cur_y_next = step_minor ? minor_nxt : cur_y;
      end
      res_s.x     = cur_x_next;
      res_s.y     = cur_y_next;
      res_s.valid = 1'b1;
      res_s.last  = (pixels_left == C'(1));
    end
  end

  // Hold or update line state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x          <= '0;
      cur_y          <= '0;
      err_term       <= '0;
      twice_major    <= '0;
      twice_minor    <= '0;
      pixels_left    <= '0;
      steep_flag     <= 1'b0;
      minor_negative <= 1'b0;
    end else if (go) begin
      cur_x          <= cur_x_next;
      cur_y          <= cur_y_next;
      err_term       <= err_term_next;
      twice_major    <= twice_major_next;
      twice_minor    <= twice_minor_next;
      pixels_left    <= pixels_left_next;
      steep_flag     <= steep_flag_next;
      minor_negative <= minor_negative_next;
    end
  end

  // Error term stays inside the Bresenham window while a line is active
  a_err_window: assert property (@(posedge clk) disable iff (rst)
    (pixels_left != '0) |->
      (err_term <= $signed({2'b00, twice_minor})) &&
      (err_term > -$signed({2'b00, twice_major})))
    else $error("error term left its window");

  // A step on an active line consumes exactly one pixel
  a_left_dec: assert property (@(posedge clk) disable iff (rst)
    (go && cmd_s.is_step && pixels_left != '0) |=>
      (pixels_left == $past(pixels_left) - 1'b1))
    else $error("pixel count did not drop by one");

  // A step with no active line leaves the state untouched
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (go && cmd_s.is_step && pixels_left == '0) |=>
      ($stable(cur_x) && $stable(cur_y) && $stable(err_term) && pixels_left == '0))
    else $error("state moved on a step without a line");

  // Major axis advances by one on every step of a shallow line
  a_major_inc: assert property (@(posedge clk) disable iff (rst)
    (go && cmd_s.is_step && pixels_left != '0 && !steep_flag) |=>
      (cur_x == $past(cur_x) + 1'b1))
    else $error("x did not advance on a shallow line");

endmodule

FILE: rtl/bresenham_line_stepper_unit.sv
`timescale 1ns / 1ps

// Bresenham line stepper. A start item (func = FUNC_START) loads two endpoints
// and yields the first pixel; every step item (func = FUNC_STEP) yields the
// next pixel, with last_point high on the final one. A step with no active
// line yields a result with point_valid low and all fields zero. Both sides
// look like queues: push/full on the input, empty/pop on the output. The unit
// takes one item per clock and delivers one result per clock as long as the
// results are popped; an item is registered in the command queue and its result
// in the result queue, whose head drives the output ports. Line setup (deltas,
// octant, endpoint order, initial error) is done as the item enters the command
// queue, and the stepper behind it computes the next position and error
// combinationally from the queue head, which sets the one-pixel-per-clock rate.
// Each queue holds QUEUE_DEPTH entries, so full and empty can stall
// independently without losing a transfer.
module bresenham_line_stepper_unit import lst_pkg::*; #(
  parameter int COORD_BITS  = LST_COORD_BITS,
  parameter int QUEUE_DEPTH = LST_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  func,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] point_x,
  output logic [COORD_BITS-1:0] point_y,
  output logic                  point_valid,
  output logic                  last_point
);

  localparam int CMD_W = lst_cmd_width(COORD_BITS);
  localparam int RES_W = lst_res_width(COORD_BITS);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  valid;
    logic                  last;
  } res_t;

  logic [CMD_W-1:0] front_cmd;
  logic [CMD_W-1:0] head_cmd;
  logic             cmd_empty;
  logic             cmd_pop;
  logic [RES_W-1:0] back_res;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] head_res;
  res_t             head_res_s;

  // Classify incoming items
  lst_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .func    (func),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .cmd     (front_cmd)
  );

  // Queue classified commands
  lst_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (head_cmd),
    .empty   (cmd_empty)
  );

  // Walk the line
  lst_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // Queue results for the consumer
  lst_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (head_res),
    .empty   (empty)
  );

  // Drive result ports from the queue head
  assign head_res_s  = head_res;
  assign point_x     = head_res_s.x;
  assign point_y     = head_res_s.y;
  assign point_valid = head_res_s.valid;
  assign last_point  = head_res_s.last;

endmodule

FILE: dv/lst_pixel_checker.sv
`timescale 1ns / 1ps

// Watches the item and pixel channels of the line stepper, predicts the pixel
// for every accepted item and compares each popped pixel with the oldest
// prediction.
module lst_pixel_checker import lst_pkg::*; #(
  parameter int COORD_BITS = LST_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  logic                  func,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  point_valid,
  input  logic                  last_point,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   valid;
    logic   last;
  } pixel_t;

  // Rasterizer state as the block should hold it
  coord_t cur_x;
  coord_t cur_y;
  int     err;
  int     twice_major;
  int     twice_minor;
  int     pixels_left;
  logic   y_major;
  logic   minor_down;

  pixel_t expected_pixels[$];

  // Work out the pixel that one item yields and advance the line state
  function pixel_t next_pixel(input logic op, input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    int     adx;
    int     ady;
    int     major;
    int     minor;
    coord_t lo_x;
    coord_t lo_y;
    coord_t hi_x;
    coord_t hi_y;
    pixel_t px;
    px = '0;
    if (op == FUNC_START) begin
      adx = (sx > ex) ? int'(sx - ex) : int'(ex - sx);
      ady = (sy > ey) ? int'(sy - ey) : int'(ey - sy);
      // equal deltas count as y-major
      y_major = !(ady < adx);
      // walk from the lower end of the major axis
      if ((!y_major && sx > ex) || (y_major && sy > ey)) begin
        lo_x = ex; lo_y = ey; hi_x = sx; hi_y = sy;
      end else begin
        lo_x = sx; lo_y = sy; hi_x = ex; hi_y = ey;
      end
      if (y_major) begin
        minor_down = (hi_x < lo_x);
        major = ady;
        minor = adx;
      end else begin
        minor_down = (hi_y < lo_y);
        major = adx;
        minor = ady;
      end
      cur_x       = lo_x;
      cur_y       = lo_y;
      twice_major = 2 * major;
      twice_minor = 2 * minor;
      err         = 2 * minor - major;
      pixels_left = major;
    end else if (pixels_left == 0) begin
      // no active line: invalid, all zero, state held
      return px;
    end else begin
      if (err > 0) begin
        if (y_major) cur_x = minor_down ? cur_x - 1'b1 : cur_x + 1'b1;
        else         cur_y = minor_down ? cur_y - 1'b1 : cur_y + 1'b1;
        err -= twice_major;
      end
      err += twice_minor;
      if (y_major) cur_y = cur_y + 1'b1;
      else         cur_x = cur_x + 1'b1;
      pixels_left--;
    end
    px.x     = cur_x;
    px.y     = cur_y;
    px.valid = 1'b1;
    px.last  = (pixels_left == 0);
    return px;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    $display("%0t: pixel %0d %s mismatch: expected %0d, got %0d",
             $realtime, checked, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_x       = '0;
      cur_y       = '0;
      err         = 0;
      twice_major = 0;
      twice_minor = 0;
      pixels_left = 0;
      y_major     = 1'b0;
      minor_down  = 1'b0;
      expected_pixels.delete();
      fail_count  = 0;
      checked     <= 0;
      pending     <= 0;
    end else begin
      // compare the popped pixel with the oldest prediction
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch("unexpected transfer", 0, 1);
        end else begin
          pixel_t want;
          want = expected_pixels.pop_front();
          if (point_x !== want.x) flag_mismatch("point_x", want.x, point_x);
          if (point_y !== want.y) flag_mismatch("point_y", want.y, point_y);
          if (point_valid !== want.valid)
            flag_mismatch("point_valid", want.valid, point_valid);
          if (last_point !== want.last)
            flag_mismatch("last_point", want.last, last_point);
        end
        checked <= checked + 1;
      end
      // predict the pixel for each accepted item, appended at the tail
      if (push && !full)
        expected_pixels.insert(expected_pixels.size(),
                               next_pixel(func, start_x, start_y, end_x, end_y));
      pending <= expected_pixels.size();
    end
  end

endmodule

FILE: dv/tb_bresenham_line_stepper_unit.sv
`timescale 1ns / 1ps

module tb_bresenham_line_stepper_unit;
  import lst_pkg::*;

  localparam int CB            = LST_COORD_BITS;
  localparam int ITEMS_PER_RUN = 1050;
  localparam int STALL_LIMIT   = 5000;

  typedef logic [CB-1:0] coord_t;

  logic   clk;
  logic   rst;
  logic   push;
  logic   full;
  logic   func;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  logic   empty;
  logic   pop;
  coord_t point_x;
  coord_t point_y;
  logic   point_valid;
  logic   last_point;

  int fail_count;
  int pending;
  int checked;
  int idle_pct;
  int stall_pct;
  int items_sent;
  int n_starts;
  int n_steps;
  int quiet_cycles;

  bresenham_line_stepper_unit #(.COORD_BITS(CB)) u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .empty       (empty),
    .pop         (pop),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_valid (point_valid),
    .last_point  (last_point)
  );

  lst_pixel_checker #(.COORD_BITS(CB)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .empty       (empty),
    .pop         (pop),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_valid (point_valid),
    .last_point  (last_point),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Randomly stall the pixel side
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d pixels waiting",
                 STALL_LIMIT, pending);
        $display("bresenham_line_stepper_unit test failed");
        $finish;
      end
    end
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, (1 << CB) - 1));
  endfunction

  function automatic int line_length(input coord_t sx, input coord_t sy,
                                     input coord_t ex, input coord_t ey);
    int adx;
    int ady;
    adx = (sx > ex) ? int'(sx - ex) : int'(ex - sx);
    ady = (sy > ey) ? int'(sy - ey) : int'(ey - sy);
    return (adx > ady) ? adx : ady;
  endfunction

  // Offer one item after a random idle gap and hold it until it transfers
  task automatic send_item(input logic op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    func    <= op;
    start_x <= sx;
    start_y <= sy;
    end_x   <= ex;
    end_y   <= ey;
    do @(posedge clk); while (full);
    items_sent++;
    if (op == FUNC_START) n_starts++;
    else n_steps++;
  endtask

  // Start a line and follow it with a number of steps carrying junk coordinates
  task automatic draw_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input int n);
    send_item(FUNC_START, sx, sy, ex, ey);
    repeat (n) send_item(FUNC_STEP, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord());
  endtask

  task automatic random_line();
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    int     len;
    int     n;
    sx = rand_coord();
    sy = rand_coord();
    // mostly short lines near a random spot, sometimes full-range endpoints
    if ($urandom_range(99) < 85) begin
      ex = sx + coord_t'($urandom_range(0, 24)) - coord_t'(12);
      ey = sy + coord_t'($urandom_range(0, 24)) - coord_t'(12);
    end else begin
      ex = rand_coord();
      ey = rand_coord();
    end
    len = line_length(sx, sy, ex, ey);
    // finish the line, or drop it partway with a new start
    if (len <= 24 && $urandom_range(99) < 80) n = len + $urandom_range(0, 2);
    else n = $urandom_range(0, (len < 20) ? len : 20);
    draw_line(sx, sy, ex, ey, n);
  endtask

  initial begin
    int phase_end;
    rst        <= 1'b1;
    push       <= 1'b0;
    func       <= FUNC_STEP;
    start_x    <= '0;
    start_y    <= '0;
    end_x      <= '0;
    end_y      <= '0;
    idle_pct   = 0;
    stall_pct  = 0;
    items_sent = 0;
    n_starts   = 0;
    n_steps    = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: step with no line, single point, equal deltas, a decreasing minor
    // axis, coordinate extremes, and restarts over an active line
    send_item(FUNC_STEP, '1, '1, '1, '1);
    draw_line(12'd5, 12'd5, 12'd5, 12'd5, 1);
    draw_line(12'd4095, 12'd0, 12'd0, 12'd4095, 2);
    draw_line(12'd0, 12'd4095, 12'd4095, 12'd4094, 2);
    draw_line(12'd3, 12'd7, 12'd10, 12'd4, 7);
    draw_line(12'd10, 12'd2, 12'd8, 12'd9, 8);

    // Random: no idling, sender idle, receiver stall, both, then none again
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        3: begin idle_pct = 24; stall_pct = 24; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      phase_end = (ph + 1) * ITEMS_PER_RUN / 5;
      while (items_sent < phase_end) begin
        // a few lone steps, mostly whole or broken lines
        if ($urandom_range(99) < 6)
          send_item(FUNC_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        else
          random_line();
      end
    end
    push <= 1'b0;

    // Drain the remaining pixels, then allow for the pipeline latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d items: %0d line starts and %0d steps", items_sent,
             n_starts, n_steps);
    $display("%0d pixels checked across idle and stall phases, %0d mismatches",
             checked, fail_count);
    if (fail_count == 0) begin
      $display("bresenham_line_stepper_unit test passed");
    end else begin
      $display("bresenham_line_stepper_unit test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lst_pkg.sv
rtl/lst_fifo.sv
rtl/lst_front.sv
rtl/lst_back.sv
rtl/bresenham_line_stepper_unit.sv
dv/lst_pixel_checker.sv
dv/tb_bresenham_line_stepper_unit.sv
